>>> sv/assert_macros.svh
// Assertion helpers for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skipped while arst_n is low.
`define GFW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define GFW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/gfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph framebuffer writer package
// Store geometry, action codes, sequencer states and the 6x8 font table.
// ----------------------------------------------------------------------------
package gfw_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES = 8;
	localparam int DEPTH = COLUMNS * PAGES;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int GLYPH_COUNT = 95;
	localparam int GLYPH_W = 6;
	localparam int CODE_FIRST = 32;
	localparam int CODE_LAST = 126;
	localparam int STEPS_X1 = GLYPH_W;
	localparam int STEPS_X2 = 4 * GLYPH_W;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_DRAW1 = 2'd1,
		ACT_DRAW2 = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAW,
		ST_READ,
		ST_DONE
	} state_t;

	localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_W] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00},
		'{8'h00,8'h07,8'h00,8'h07,8'h00,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14,8'h00},
		'{8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h00}, '{8'h23,8'h13,8'h08,8'h64,8'h62,8'h00},
		'{8'h36,8'h49,8'h55,8'h22,8'h50,8'h00}, '{8'h00,8'h05,8'h03,8'h00,8'h00,8'h00},
		'{8'h00,8'h1C,8'h22,8'h41,8'h00,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00,8'h00},
		'{8'h08,8'h2A,8'h1C,8'h2A,8'h08,8'h00}, '{8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00},
		'{8'h00,8'h50,8'h30,8'h00,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08,8'h00},
		'{8'h00,8'h60,8'h60,8'h00,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02,8'h00},
		'{8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00}, '{8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00},
		'{8'h42,8'h61,8'h51,8'h49,8'h46,8'h00}, '{8'h21,8'h41,8'h45,8'h4B,8'h31,8'h00},
		'{8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00}, '{8'h27,8'h45,8'h45,8'h45,8'h39,8'h00},
		'{8'h3C,8'h4A,8'h49,8'h49,8'h30,8'h00}, '{8'h01,8'h71,8'h09,8'h05,8'h03,8'h00},
		'{8'h36,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h06,8'h49,8'h49,8'h29,8'h1E,8'h00},
		'{8'h00,8'h36,8'h36,8'h00,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00,8'h00},
		'{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h00},
		'{8'h41,8'h22,8'h14,8'h08,8'h00,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06,8'h00},
		'{8'h32,8'h49,8'h79,8'h41,8'h3E,8'h00}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E,8'h00},
		'{8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00},
		'{8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h00}, '{8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00},
		'{8'h7F,8'h09,8'h09,8'h01,8'h01,8'h00}, '{8'h3E,8'h41,8'h41,8'h51,8'h32,8'h00},
		'{8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00}, '{8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00},
		'{8'h20,8'h40,8'h41,8'h3F,8'h01,8'h00}, '{8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00},
		'{8'h7F,8'h40,8'h40,8'h40,8'h40,8'h00}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F,8'h00},
		'{8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00},
		'{8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00},
		'{8'h7F,8'h09,8'h19,8'h29,8'h46,8'h00}, '{8'h46,8'h49,8'h49,8'h49,8'h31,8'h00},
		'{8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00},
		'{8'h1F,8'h20,8'h40,8'h20,8'h1F,8'h00}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F,8'h00},
		'{8'h63,8'h14,8'h08,8'h14,8'h63,8'h00}, '{8'h03,8'h04,8'h78,8'h04,8'h03,8'h00},
		'{8'h61,8'h51,8'h49,8'h45,8'h43,8'h00}, '{8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00},
		'{8'h02,8'h04,8'h08,8'h10,8'h20,8'h00}, '{8'h41,8'h41,8'h7F,8'h00,8'h00,8'h00},
		'{8'h04,8'h02,8'h01,8'h02,8'h04,8'h00}, '{8'h40,8'h40,8'h40,8'h40,8'h40,8'h00},
		'{8'h00,8'h01,8'h02,8'h04,8'h00,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78,8'h00},
		'{8'h7F,8'h48,8'h44,8'h44,8'h38,8'h00}, '{8'h38,8'h44,8'h44,8'h44,8'h20,8'h00},
		'{8'h38,8'h44,8'h44,8'h48,8'h7F,8'h00}, '{8'h38,8'h54,8'h54,8'h54,8'h18,8'h00},
		'{8'h08,8'h7E,8'h09,8'h01,8'h02,8'h00}, '{8'h08,8'h14,8'h54,8'h54,8'h3C,8'h00},
		'{8'h7F,8'h08,8'h04,8'h04,8'h78,8'h00}, '{8'h00,8'h44,8'h7D,8'h40,8'h00,8'h00},
		'{8'h20,8'h40,8'h44,8'h3D,8'h00,8'h00}, '{8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00},
		'{8'h00,8'h41,8'h7F,8'h40,8'h00,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78,8'h00},
		'{8'h7C,8'h08,8'h04,8'h04,8'h78,8'h00}, '{8'h38,8'h44,8'h44,8'h44,8'h38,8'h00},
		'{8'h7C,8'h14,8'h14,8'h14,8'h08,8'h00}, '{8'h08,8'h14,8'h14,8'h18,8'h7C,8'h00},
		'{8'h7C,8'h08,8'h04,8'h04,8'h08,8'h00}, '{8'h48,8'h54,8'h54,8'h54,8'h20,8'h00},
		'{8'h04,8'h3F,8'h44,8'h40,8'h20,8'h00}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C,8'h00},
		'{8'h1C,8'h20,8'h40,8'h20,8'h1C,8'h00}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C,8'h00},
		'{8'h44,8'h28,8'h10,8'h28,8'h44,8'h00}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C,8'h00},
		'{8'h44,8'h64,8'h54,8'h4C,8'h44,8'h00}, '{8'h00,8'h08,8'h36,8'h41,8'h00,8'h00},
		'{8'h00,8'h00,8'h7F,8'h00,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00,8'h00},
		'{8'h08,8'h08,8'h2A,8'h1C,8'h08,8'h00}
	};

	// Map a character code to its font row; unprintable codes map to space.
	function automatic logic [6:0] glyph_index(input logic [7:0] code);
		logic [6:0] idx;
		idx = 7'd0;
		if (int'(code) >= CODE_FIRST && int'(code) <= CODE_LAST) begin
			idx = 7'(int'(code) - CODE_FIRST);
		end
		return idx;
	endfunction

	// One font column; column codes past the glyph width read as blank.
	function automatic logic [7:0] glyph_byte(input logic [6:0] idx, input logic [2:0] col);
		logic [7:0] b;
		b = 8'h00;
		if (int'(col) < GLYPH_W && int'(idx) < GLYPH_COUNT) begin
			b = GLYPH_ROM[idx][col];
		end
		return b;
	endfunction

	// Double each of four bits vertically into one byte.
	function automatic logic [7:0] stretch_nibble(input logic [3:0] src);
		logic [7:0] r;
		for (int b = 0; b < 4; b++) begin
			r[2*b]   = src[b];
			r[2*b+1] = src[b];
		end
		return r;
	endfunction

endpackage

>>> sv/glyph_framebuffer_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph framebuffer writer
// Page-organized monochrome framebuffer drawn from a built-in 6x8 font.
// ----------------------------------------------------------------------------
// The frame lives in one single-port RAM of PAGES x COLUMNS bytes (bit 0 of a
// byte is the top pixel line of its page), and every action below goes
// through that one port, one stored byte at a time. A word on the input does
// one of four things. Clear writes zero to all 1024 bytes. A normal glyph
// writes 6 bytes. A double-size glyph writes 24 bytes (each font column twice,
// each font bit stretched over two lines, upper half on the given page and
// lower half on the page below). A read returns the stored byte; every other
// action returns zero. Columns at or past the right edge and a lower half
// below the last page are simply not written; reading outside the frame gives
// zero. Codes outside 32..126 draw a space. After reset the block runs the
// same clearing pass over all 1024 bytes before in_ready first rises. One word
// is in work at a time; a finished result sits in an output register, so the
// next word is taken while the result waits.
// ----------------------------------------------------------------------------
module glyph_framebuffer_writer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [6:0] column,
	input  logic [2:0] page,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data
);

	import gfw_pkg::*;

	// Sequencer state
	state_t              state_q, state_d;
	logic [4:0]          step_q, step_d;
	logic [ADDR_W-1:0]   clr_q, clr_d;
	logic                item_q, item_d;      // clear pass answers a word
	logic                out_valid_q, out_valid_d;
	logic [7:0]          read_data_q, read_data_d;

	// Latched word
	action_t             act_q;
	logic [6:0]          col_q;
	logic [2:0]          page_q;
	logic [6:0]          glyph_q;

	// Address generation
	logic                dbl;
	logic [3:0]          col_off;
	logic                pg_off;
	logic [2:0]          font_col;
	logic [7:0]          font_byte;
	logic [7:0]          draw_byte;
	logic [3:0]          pg_sum;
	logic [7:0]          cx;
	logic                in_range;
	logic [ADDR_W-1:0]   frame_addr;
	logic [4:0]          last_step;

	// RAM port
	logic                ram_en;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [7:0]          ram_wdata;
	logic [7:0]          ram_rdata;

	logic                accept;
	logic                out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Double glyph step: bits 4:2 pick the font column, bit 0 the copy of
	// that column, bit 1 the lower page. Normal glyph: step is the column.
	assign dbl       = (act_q == ACT_DRAW2);
	assign font_col  = dbl ? step_q[4:2] : step_q[2:0];
	assign col_off   = dbl ? ({step_q[4:2], 1'b0} + {3'b000, step_q[0]})
	                       : {1'b0, step_q[2:0]};
	assign pg_off    = dbl && step_q[1];
	assign last_step = dbl ? 5'(STEPS_X2 - 1) : 5'(STEPS_X1 - 1);

	assign font_byte = glyph_byte(glyph_q, font_col);
	always_comb begin
		draw_byte = font_byte;
		if (dbl) begin
			draw_byte = pg_off ? stretch_nibble(font_byte[7:4])
			                   : stretch_nibble(font_byte[3:0]);
		end
	end

	// Frame position of the current step; clip against the frame edges.
	assign pg_sum     = {1'b0, page_q} + {3'b000, pg_off};
	assign cx         = {1'b0, col_q} + {4'b0000, col_off};
	assign in_range   = (int'(pg_sum) < PAGES) && (int'(cx) < COLUMNS);
	assign frame_addr = ADDR_W'(int'(pg_sum) * COLUMNS + int'(cx));

	// Next state and RAM control
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		clr_d       = clr_q;
		item_d      = item_q;
		out_valid_d = out_valid_q;
		read_data_d = read_data_q;
		ram_en      = 1'b0;
		ram_we      = 1'b0;
		ram_addr    = frame_addr;
		ram_wdata   = draw_byte;

		// Drop the result once it is taken.
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = 8'h00;
				clr_d     = clr_q + 1'b1;
				if (int'(clr_q) == DEPTH - 1) begin
					state_d = item_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					step_d = '0;
					clr_d  = '0;
					item_d = 1'b1;
					case (action_t'(action))
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_DRAW1: state_d = ST_DRAW;
						ACT_DRAW2: state_d = ST_DRAW;
						ACT_READ:  state_d = ST_READ;
						default:   state_d = ST_READ;
					endcase
				end
			end
			ST_DRAW: begin
				ram_en = in_range;
				ram_we = in_range;
				step_d = step_q + 1'b1;
				if (step_q == last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				// Step is zero here, so the address is the requested byte.
				ram_en  = in_range;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// Hold until the output register is free.
				if (out_free) begin
					out_valid_d = 1'b1;
					read_data_d = (act_q == ACT_READ && in_range) ? ram_rdata : 8'h00;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			clr_q       <= '0;
			item_q      <= 1'b0;
			out_valid_q <= 1'b0;
			act_q       <= ACT_CLEAR;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			clr_q       <= clr_d;
			item_q      <= item_d;
			out_valid_q <= out_valid_d;
			if (accept) begin
				act_q <= action_t'(action);
			end
		end
	end

	// Word fields and result byte carry no reset.
	always_ff @(posedge clk) begin
		read_data_q <= read_data_d;
		if (accept) begin
			col_q   <= column;
			page_q  <= page;
			glyph_q <= glyph_index(char_code);
		end
	end

	gfw_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

>>> sv/gfw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with the read word registered.
// ----------------------------------------------------------------------------
module gfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> sv/gfw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph framebuffer writer checker
// Port-level checks on the handshakes and on quiet ports during reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data
);

	// A stalled result stays put.
	`GFW_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(read_data)), "result changed while stalled")

	// One word in work at a time: ready drops right after a word is taken.
	`GFW_ASSERT(a_one_in_work, (in_valid && in_ready) |=> !in_ready, "word taken while another is in work")

	// While in reset nothing is offered or taken.
	`GFW_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!in_ready && !out_valid), "handshake active in reset")

endmodule

bind glyph_framebuffer_writer_unit gfw_checker u_gfw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.read_data(read_data)
);
